/* design/eots_pkg.sv */
// Package for the EDNS option TLV scanner: phase codes, result kinds,
// the event record passed from the parser to the output side.
// No dependencies.
`timescale 1ns / 1ps

package eots_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned EVQ_DEPTH_DEF = 4;

    localparam logic [PHASE_W-1:0] PH_CODE_HI = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_LO = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BODY    = 3'd4;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    // One parser event: an optional option record followed by an optional summary.
    typedef struct packed {
        logic              rec_valid;
        logic              sum_valid;
        logic              rec_last;
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] length;
        logic              code_hit;
        logic              found;
        logic [WORD_W-1:0] found_offset;
        logic              status;
    } t_event;

endpackage

/* design/eots_front.sv */
// Front part of the EDNS option TLV scanner: walks the option headers and
// bodies byte by byte and emits one event per byte that completes something.
// Depends on eots_pkg.
`timescale 1ns / 1ps

module eots_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [eots_pkg::WORD_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    input  logic [eots_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_last,
    input  logic                         i_q_ready,
    output logic                         o_ready,
    output logic                         o_push,
    output eots_pkg::t_event             o_event
);
    import eots_pkg::*;

    logic [WORD_W-1:0]  r_wanted;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [WORD_W-1:0]  r_pos,    n_pos;
    logic [WORD_W-1:0]  r_code,   n_code;
    logic [WORD_W-1:0]  r_length, n_length;
    logic [WORD_W-1:0]  r_remain, n_remain;
    logic [WORD_W-1:0]  r_start,  n_start;
    logic               r_seen,   n_seen;
    logic [WORD_W-1:0]  r_moff,   n_moff;

    logic              accept;
    logic              done;
    logic [WORD_W-1:0] rem_dec;
    logic [WORD_W-1:0] rec_length;
    logic              match;

    assign accept  = i_valid && i_q_ready;
    assign o_ready = i_q_ready;
    assign rem_dec = r_remain - 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_length = r_length;
        n_remain = r_remain;
        n_start  = r_start;
        done     = 1'b0;
        unique case (r_phase)
            PH_CODE_LO: begin
                n_code  = {r_code[WORD_W-1:BYTE_W], i_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = {i_byte, {BYTE_W{1'b0}}};
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {r_length[WORD_W-1:BYTE_W], i_byte};
                n_remain = {r_length[WORD_W-1:BYTE_W], i_byte};
                if ({r_length[WORD_W-1:BYTE_W], i_byte} == '0) begin
                    done    = 1'b1;
                    n_phase = PH_CODE_HI;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_remain = rem_dec;
                if (rem_dec == '0) begin
                    done    = 1'b1;
                    n_phase = PH_CODE_HI;
                end
            end
            default: begin
                n_start = r_pos;
                n_code  = {i_byte, {BYTE_W{1'b0}}};
                n_phase = PH_CODE_LO;
            end
        endcase
        n_pos = r_pos + 16'd1;
    end

    assign rec_length = n_length;
    assign match      = (r_code == r_wanted);

    always_comb begin
        n_seen = r_seen;
        n_moff = r_moff;
        if (done && match && !r_seen) begin
            n_seen = 1'b1;
            n_moff = r_start;
        end
    end

    always_comb begin
        o_event              = '0;
        o_event.rec_valid    = done;
        o_event.sum_valid    = i_last;
        o_event.rec_last     = !i_last;
        o_event.code         = r_code;
        o_event.offset       = r_start;
        o_event.length       = rec_length;
        o_event.code_hit     = match;
        o_event.found        = n_seen;
        o_event.found_offset = n_seen ? n_moff : '0;
        o_event.status       = (n_phase == PH_CODE_HI) ? STATUS_OK : STATUS_TRUNC;
    end

    assign o_push = accept && (done || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= '0;
        end else if (i_cfg_we) begin
            r_wanted <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CODE_HI;
            r_pos    <= '0;
            r_code   <= '0;
            r_length <= '0;
            r_remain <= '0;
            r_start  <= '0;
            r_seen   <= 1'b0;
            r_moff   <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_phase  <= PH_CODE_HI;
                r_pos    <= '0;
                r_code   <= '0;
                r_length <= '0;
                r_remain <= '0;
                r_start  <= '0;
                r_seen   <= 1'b0;
                r_moff   <= '0;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_code   <= n_code;
                r_length <= n_length;
                r_remain <= n_remain;
                r_start  <= n_start;
                r_seen   <= n_seen;
                r_moff   <= n_moff;
            end
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_phase == PH_CODE_HI && r_pos == '0 && !r_seen)
        else $error("walk state not cleared after final byte");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_remain != '0)
        else $error("body phase with nothing left to consume");

    a_match_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> r_moff == '0)
        else $error("match offset set without a match");

endmodule

/* design/eots_queue.sv */
// Event queue between the parser and the output sequencer.
// Small register FIFO with occupancy count. Depends on eots_pkg.
`timescale 1ns / 1ps

module eots_queue #(
    parameter int unsigned DEPTH = eots_pkg::EVQ_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  eots_pkg::t_event  i_event,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_nonempty,
    output eots_pkg::t_event  o_event
);
    import eots_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_event          r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    assign o_ready    = (r_count != FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_event    = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_IDX) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_IDX) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* design/eots_back.sv */
// Back part of the EDNS option TLV scanner: takes events from the queue and
// drives the result stream, record first, then the summary.
// Depends on eots_pkg.
`timescale 1ns / 1ps

module eots_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_nonempty,
    input  eots_pkg::t_event                   i_event,
    output logic                               o_pop,
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [eots_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic                               o_tuser,
    output logic                               o_tlast
);
    import eots_pkg::*;

    logic                   r_valid;
    logic                   r_kind;
    logic                   r_last;
    logic [OUT_TDATA_W-1:0] r_data;
    logic                   r_pend_sum;
    logic                   r_sum_found;
    logic [WORD_W-1:0]      r_sum_foff;
    logic                   r_sum_status;

    logic                   load;
    logic [OUT_TDATA_W-1:0] rec_data;
    logic [OUT_TDATA_W-1:0] sum_data;
    logic [OUT_TDATA_W-1:0] held_sum_data;

    assign load  = !r_valid || i_tready;
    assign o_pop = load && !r_pend_sum && i_q_nonempty;

    // tdata: code, offset, length, code_matches, found, found_offset, status, pad
    assign rec_data = {5'd0, STATUS_OK, {WORD_W{1'b0}}, 1'b0, i_event.code_hit,
                       i_event.length, i_event.offset, i_event.code};
    assign sum_data = {5'd0, i_event.status, i_event.found_offset, i_event.found, 1'b0,
                       {(3*WORD_W){1'b0}}};
    assign held_sum_data = {5'd0, r_sum_status, r_sum_foff, r_sum_found, 1'b0,
                            {(3*WORD_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pend_sum <= 1'b0;
        end else if (load) begin
            if (r_pend_sum) begin
                r_valid    <= 1'b1;
                r_pend_sum <= 1'b0;
            end else if (i_q_nonempty) begin
                r_valid    <= 1'b1;
                r_pend_sum <= i_event.rec_valid && i_event.sum_valid;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend_sum) begin
                r_kind <= KIND_SUMMARY;
                r_last <= 1'b1;
                r_data <= held_sum_data;
            end else if (i_q_nonempty) begin
                r_sum_found  <= i_event.found;
                r_sum_foff   <= i_event.found_offset;
                r_sum_status <= i_event.status;
                if (i_event.rec_valid) begin
                    r_kind <= KIND_RECORD;
                    r_last <= i_event.rec_last;
                    r_data <= rec_data;
                end else begin
                    r_kind <= KIND_SUMMARY;
                    r_last <= 1'b1;
                    r_data <= sum_data;
                end
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

    a_pend_behind_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_sum |-> r_valid && r_kind == KIND_RECORD && !r_last)
        else $error("summary pending without its record in the output slot");

    a_summary_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_SUMMARY |-> r_last)
        else $error("summary transfer not marked last");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_nonempty && !r_pend_sum)
        else $error("queue popped while empty or summary pending");

endmodule

/* design/edns_option_tlv_scanner.sv */
// Top level of the EDNS option TLV scanner: parser front, event queue, output back.
// Depends on eots_pkg, eots_front, eots_queue, eots_back.
`timescale 1ns / 1ps

// Takes one option-area byte per cycle and sustains one byte per clock. Each
// byte is parsed combinationally; a byte that completes an option or ends the
// area leaves one event in a queue of EVQ_DEPTH entries. The output register
// sends one transfer per cycle while the receiver is ready: a completed option
// record and, on the final byte, a summary after it, so a final byte that also
// closes an option yields two transfers. The input stalls only when the queue
// is full. wanted_code may be written at any time the block is idle.

module edns_option_tlv_scanner #(
    parameter int unsigned EVQ_DEPTH = eots_pkg::EVQ_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [eots_pkg::WORD_W-1:0]        i_cfg_data,   // wanted_code
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [eots_pkg::BYTE_W-1:0]        i_s_tdata,    // data_byte
    input  logic                               i_s_tlast,    // last_byte
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] option_code, [31:16] option_offset, [47:32] option_length,
    // [48] code_matches, [49] found, [65:50] found_offset, [66] status, [71:67] zero
    output logic [eots_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tuser,    // result_kind
    output logic                               o_m_tlast     // last_result
);
    import eots_pkg::*;

    logic   q_ready;
    logic   push;
    logic   pop;
    logic   q_nonempty;
    t_event front_event;
    t_event head_event;

    assign o_cfg_ready = 1'b1;

    eots_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_q_ready  (q_ready),
        .o_ready    (o_s_tready),
        .o_push     (push),
        .o_event    (front_event)
    );

    eots_queue #(
        .DEPTH (EVQ_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_event    (front_event),
        .o_ready    (q_ready),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_event    (head_event)
    );

    eots_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_event      (head_event),
        .o_pop        (pop),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_tdata      (o_m_tdata),
        .o_tuser      (o_m_tuser),
        .o_tlast      (o_m_tlast)
    );

endmodule
